// ----- rtl/keyed_rating_table_assert.svh -----
// assertion macros used by the table rtl
`ifndef KEYED_RATING_TABLE_ASSERT_SVH
`define KEYED_RATING_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define KRT_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("keyed rating table check failed");

// condition must never be seen outside reset
`define KRT_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("keyed rating table forbidden condition seen");

`else

`define KRT_ASSERT(lbl, clk_s, rstn_s, prop)
`define KRT_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)

`endif

`endif

// ----- rtl/krt_pkg.sv -----
`default_nettype none

package krt_pkg;

  localparam int TableEntries = 64;
  localparam int AddrW        = $clog2(TableEntries);
  localparam int CntW         = AddrW + 1;
  localparam int KeyW         = 32;
  localparam int RatingW      = 16;
  localparam int SumW         = RatingW + AddrW;
  localparam int EntryW       = 2 * KeyW + RatingW;
  localparam int StatusW      = 3;
  localparam int MatchW       = 7;
  localparam int MatchMax     = 127;
  localparam int StepW        = $clog2(SumW + 1);

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_GET     = 2'd2,
    CMD_AVERAGE = 2'd3
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_VALUE     = 3'd5
  } status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/keyed_rating_table.sv -----
// channel | handshake            | fields
// in      | in_valid, in_stall   | in_cmd in_user_key in_item_key in_rating_in
// out     | out_valid, out_stall | out_status out_value_out out_match_count
//
// every command scans all TableEntries slots through the single read port of
// the entry ram, one slot a cycle. an average over a non-empty set of entries
// then adds the bit-serial divider.
// reset is synchronous, active low, and clears every valid mark at once.
// a new word is taken while the previous result still waits under out_stall
`default_nettype none

module keyed_rating_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [krt_pkg::KeyW-1:0]      in_user_key,
  input  wire logic [krt_pkg::KeyW-1:0]      in_item_key,
  input  wire logic signed [krt_pkg::RatingW-1:0] in_rating_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [krt_pkg::StatusW-1:0]        out_status,
  output logic signed [krt_pkg::RatingW-1:0] out_value_out,
  output logic [krt_pkg::MatchW-1:0]         out_match_count
);

  `include "keyed_rating_table_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIVGO,
    S_DIV,
    S_UPD,
    S_FIN
  } state_t;

  state_t                               state_r;
  krt_pkg::cmd_t                        cmd_r;
  logic [krt_pkg::KeyW-1:0]             user_r;
  logic [krt_pkg::KeyW-1:0]             item_r;
  logic [krt_pkg::RatingW-1:0]          rating_r;
  logic [krt_pkg::TableEntries-1:0]     valid_r;
  logic [krt_pkg::CntW-1:0]             cnt_r;
  logic                                 rd_pend_r;
  logic [krt_pkg::AddrW-1:0]            rd_idx_r;
  logic                                 hit_r;
  logic [krt_pkg::AddrW-1:0]            hit_idx_r;
  logic [krt_pkg::RatingW-1:0]          hit_rating_r;
  logic                                 free_r;
  logic [krt_pkg::AddrW-1:0]            free_idx_r;
  logic signed [krt_pkg::SumW-1:0]      sum_r;
  logic [krt_pkg::CntW-1:0]             cnt_match_r;
  logic                                 out_valid_r;
  logic [krt_pkg::StatusW-1:0]          out_status_r;
  logic [krt_pkg::RatingW-1:0]          out_value_r;
  logic [krt_pkg::MatchW-1:0]           out_match_r;

  logic                                 accept;
  logic                                 ram_we;
  logic [krt_pkg::AddrW-1:0]            ram_waddr;
  logic [krt_pkg::EntryW-1:0]           ram_wdata;
  logic [krt_pkg::EntryW-1:0]           ram_rdata;
  logic [krt_pkg::KeyW-1:0]             rd_user;
  logic [krt_pkg::KeyW-1:0]             rd_item;
  logic [krt_pkg::RatingW-1:0]          rd_rating;
  logic                                 rd_vbit;
  logic                                 pair_hit;
  logic                                 item_hit;
  logic                                 scan_last;
  logic                                 out_free;
  logic                                 add_new;
  logic                                 div_start;
  logic [krt_pkg::SumW-1:0]             sum_mag;
  krt_pkg::div_stat_t                   div_stat;
  logic [krt_pkg::SumW-1:0]             div_quot;
  logic [krt_pkg::RatingW-1:0]          avg_val;
  krt_pkg::status_t                     res_status;
  logic [krt_pkg::RatingW-1:0]          res_value;
  logic [krt_pkg::MatchW-1:0]           res_match;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // entry word: user, item, rating
  assign rd_user   = ram_rdata[krt_pkg::EntryW-1 -: krt_pkg::KeyW];
  assign rd_item   = ram_rdata[krt_pkg::RatingW +: krt_pkg::KeyW];
  assign rd_rating = ram_rdata[krt_pkg::RatingW-1:0];
  assign rd_vbit   = valid_r[rd_idx_r];
  assign item_hit  = rd_vbit && (rd_item == item_r);
  assign pair_hit  = item_hit && (rd_user == user_r);
  assign scan_last = rd_pend_r && (rd_idx_r == krt_pkg::AddrW'(krt_pkg::TableEntries - 1));

  assign add_new   = (state_r == S_UPD) && (cmd_r == krt_pkg::CMD_INSERT) && !hit_r && free_r;

  assign ram_we    = (state_r == S_UPD) && (cmd_r == krt_pkg::CMD_INSERT) && (hit_r || free_r);
  assign ram_waddr = hit_r ? hit_idx_r : free_idx_r;
  assign ram_wdata = {user_r, item_r, rating_r};

  krt_ram #(
    .Width (krt_pkg::EntryW),
    .Depth (krt_pkg::TableEntries)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[krt_pkg::AddrW-1:0]),
    .rdata (ram_rdata)
  );

  assign sum_mag   = sum_r[krt_pkg::SumW-1] ? krt_pkg::SumW'(-sum_r) : krt_pkg::SumW'(sum_r);
  assign div_start = (state_r == S_DIVGO) && (cnt_match_r != '0);

  krt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (cnt_match_r),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // truncation toward zero: divide magnitudes, then restore the sign
  assign avg_val = krt_pkg::RatingW'(sum_r[krt_pkg::SumW-1] ? (~div_quot + 1'b1) : div_quot);

  always_comb begin
    res_status = krt_pkg::ST_NOT_FOUND;
    res_value  = '0;
    res_match  = krt_pkg::MatchW'(hit_r);
    case (cmd_r)
      krt_pkg::CMD_INSERT: begin
        if (hit_r) begin
          res_status = krt_pkg::ST_UPDATED;
        end else if (free_r) begin
          res_status = krt_pkg::ST_ADDED;
        end else begin
          res_status = krt_pkg::ST_FULL;
        end
      end
      krt_pkg::CMD_REMOVE: begin
        res_status = hit_r ? krt_pkg::ST_REMOVED : krt_pkg::ST_NOT_FOUND;
      end
      krt_pkg::CMD_GET: begin
        if (hit_r) begin
          res_status = krt_pkg::ST_VALUE;
          res_value  = hit_rating_r;
        end
      end
      krt_pkg::CMD_AVERAGE: begin
        res_status = krt_pkg::ST_VALUE;
        res_value  = (cnt_match_r == '0) ? '0 : avg_val;
        res_match  = (32'(cnt_match_r) > 32'(krt_pkg::MatchMax)) ?
                     krt_pkg::MatchW'(krt_pkg::MatchMax) : krt_pkg::MatchW'(cnt_match_r);
      end
      default: begin
        res_status = krt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= (state_r == S_SCAN) && (cnt_r < krt_pkg::CntW'(krt_pkg::TableEntries));
      rd_idx_r  <= cnt_r[krt_pkg::AddrW-1:0];
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r       <= krt_pkg::cmd_t'(in_cmd);
            user_r      <= in_user_key;
            item_r      <= in_item_key;
            rating_r    <= in_rating_in;
            cnt_r       <= '0;
            hit_r       <= 1'b0;
            free_r      <= 1'b0;
            sum_r       <= '0;
            cnt_match_r <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r < krt_pkg::CntW'(krt_pkg::TableEntries)) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (rd_pend_r) begin
            // lowest matching slot and lowest free slot win
            if (pair_hit && !hit_r) begin
              hit_r        <= 1'b1;
              hit_idx_r    <= rd_idx_r;
              hit_rating_r <= rd_rating;
            end
            if (!rd_vbit && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= rd_idx_r;
            end
            if (item_hit) begin
              sum_r       <= sum_r + krt_pkg::SumW'(signed'(rd_rating));
              cnt_match_r <= cnt_match_r + 1'b1;
            end
          end
          if (scan_last) begin
            state_r <= (cmd_r == krt_pkg::CMD_AVERAGE) ? S_DIVGO : S_UPD;
          end
        end
        S_DIVGO: begin
          state_r <= (cnt_match_r == '0) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_FIN;
          end
        end
        S_UPD: begin
          if (cmd_r == krt_pkg::CMD_INSERT && !hit_r && free_r) begin
            valid_r[free_idx_r] <= 1'b1;
          end
          if (cmd_r == krt_pkg::CMD_REMOVE && hit_r) begin
            valid_r[hit_idx_r] <= 1'b0;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_status_r <= res_status;
            out_value_r  <= res_value;
            out_match_r  <= res_match;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_out   = out_value_r;
  assign out_match_count = out_match_r;

  `KRT_ASSERT(a_idle_no_read, clk, rst_n, !in_stall |-> !rd_pend_r)
  `KRT_ASSERT(a_add_sets_valid, clk, rst_n, add_new |=> valid_r[$past(free_idx_r)])
  `KRT_ASSERT_NEVER(a_div_stray, clk, rst_n, div_stat.done && (state_r != S_DIV))
  `KRT_ASSERT_NEVER(a_div_busy_stray, clk, rst_n, div_stat.busy && (state_r != S_DIV))

endmodule

`default_nettype wire

// ----- rtl/krt_ram.sv -----
`default_nettype none

module krt_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/krt_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module krt_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [krt_pkg::SumW-1:0]   dividend,
  input  wire logic [krt_pkg::CntW-1:0]   divisor,
  output krt_pkg::div_stat_t              stat,
  output logic      [krt_pkg::SumW-1:0]   quotient
);

  logic                       busy_r;
  logic                       done_r;
  logic [krt_pkg::StepW-1:0]  step_r;
  logic [krt_pkg::CntW-1:0]   rem_r;
  logic [krt_pkg::SumW-1:0]   quo_r;
  logic [krt_pkg::CntW-1:0]   div_r;
  logic [krt_pkg::CntW:0]     shifted;
  logic [krt_pkg::CntW:0]     diff;
  logic                       ge;

  assign shifted = {rem_r, quo_r[krt_pkg::SumW-1]};
  assign ge      = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
      end else if (busy_r) begin
        // remainder stays below the divisor, so it fits the narrow width
        rem_r  <= ge ? diff[krt_pkg::CntW-1:0] : shifted[krt_pkg::CntW-1:0];
        quo_r  <= {quo_r[krt_pkg::SumW-2:0], ge};
        step_r <= step_r + 1'b1;
        if (step_r == krt_pkg::StepW'(krt_pkg::SumW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ----- verif/keyed_rating_table_tb.sv -----
`timescale 1ns / 100ps

module keyed_rating_table_tb;
  import krt_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam logic [KeyW-1:0] KEY_ONES = '1;
  localparam logic signed [RatingW-1:0] RATING_MIN = 16'sh8000;
  localparam logic signed [RatingW-1:0] RATING_MAX = 16'sh7fff;

  typedef struct packed {
    cmd_t                      cmd;
    logic [KeyW-1:0]           user;
    logic [KeyW-1:0]           itm;
    logic signed [RatingW-1:0] rating;
  } rating_cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [RatingW-1:0] value;
    logic [MatchW-1:0]         count;
  } rating_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_GET;
  logic [KeyW-1:0] in_user_key = '0;
  logic [KeyW-1:0] in_item_key = '0;
  logic signed [RatingW-1:0] in_rating_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [StatusW-1:0] out_status;
  logic signed [RatingW-1:0] out_value_out;
  logic [MatchW-1:0] out_match_count;

  keyed_rating_table u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_user_key     (in_user_key),
    .in_item_key     (in_item_key),
    .in_rating_in    (in_rating_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_match_count (out_match_count)
  );

  always #5 clk = ~clk;

  rating_cmd_t   pending_cmds[$];
  rating_reply_t due_replies[$];

  // shadow copy of the table
  logic                      slot_valid [TableEntries];
  logic [KeyW-1:0]           slot_user  [TableEntries];
  logic [KeyW-1:0]           slot_item  [TableEntries];
  logic signed [RatingW-1:0] slot_rating[TableEntries];

  logic [KeyW-1:0] user_pool[6];
  logic [KeyW-1:0] item_pool[3];

  int total_cmds = 0;
  int words_taken = 0;
  int replies_seen = 0;
  int mismatches = 0;
  int widest_average = 0;
  int status_tally[6];
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left = 0;
  int hold_index = 0;
  int unsigned cycles = 0;
  logic word_taken = 1'b0;

  function automatic rating_reply_t apply_to_table(rating_cmd_t w);
    rating_reply_t r;
    int hit;
    int n;
    longint sum;
    r.status = ST_NOT_FOUND;
    r.value  = '0;
    r.count  = '0;
    hit = -1;
    n = 0;
    sum = 0;
    for (int s = 0; s < TableEntries; s++)
      if (hit < 0 && slot_valid[s] && slot_user[s] == w.user && slot_item[s] == w.itm)
        hit = s;
    case (w.cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          slot_rating[hit] = w.rating;
          r.status = ST_UPDATED;
          r.count  = 1;
        end else begin
          r.status = ST_FULL;
          for (int s = 0; s < TableEntries; s++) begin
            if (!slot_valid[s] && r.status == ST_FULL) begin
              slot_valid[s]  = 1'b1;
              slot_user[s]   = w.user;
              slot_item[s]   = w.itm;
              slot_rating[s] = w.rating;
              r.status = ST_ADDED;
            end
          end
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          slot_valid[hit] = 1'b0;
          r.status = ST_REMOVED;
          r.count  = 1;
        end
      end
      CMD_GET: begin
        if (hit >= 0) begin
          r.value  = slot_rating[hit];
          r.status = ST_VALUE;
          r.count  = 1;
        end
      end
      default: begin
        for (int s = 0; s < TableEntries; s++) begin
          if (slot_valid[s] && slot_item[s] == w.itm) begin
            sum += longint'(slot_rating[s]);
            n++;
          end
        end
        r.status = ST_VALUE;
        // signed division truncates toward zero
        if (n > 0) r.value = RatingW'(sum / n);
        r.count = (n > MatchMax) ? MatchW'(MatchMax) : MatchW'(n);
      end
    endcase
    return r;
  endfunction

  function automatic logic [KeyW-1:0] new_key();
    case ($urandom_range(9))
      0: return '0;
      1: return KEY_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [RatingW-1:0] random_rating();
    case ($urandom_range(9))
      0: return RATING_MIN;
      1: return RATING_MAX;
      2: return '0;
      3: return RatingW'($signed($urandom_range(8)) - 4);
      default: return RatingW'($urandom);
    endcase
  endfunction

  task automatic queue_cmd(cmd_t c, logic [KeyW-1:0] u, logic [KeyW-1:0] i,
                           logic signed [RatingW-1:0] r);
    rating_cmd_t w;
    w.cmd    = c;
    w.user   = u;
    w.itm    = i;
    w.rating = r;
    pending_cmds.push_back(w);
  endtask

  // remove every pair the pools can form, then average each pooled item
  task automatic queue_pool_drain();
    for (int u = 0; u < 6; u++)
      for (int i = 0; i < 3; i++)
        queue_cmd(CMD_REMOVE, user_pool[u], item_pool[i], random_rating());
    for (int i = 0; i < 3; i++)
      queue_cmd(CMD_AVERAGE, new_key(), item_pool[i], random_rating());
  endtask

  always @* begin
    if (words_taken < total_cmds / 3) begin
      tx_idle_pct = 35;
      rx_idle_pct = 72;
    end else if (words_taken < 2 * total_cmds / 3) begin
      tx_idle_pct = 72;
      rx_idle_pct = 35;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  always @(negedge clk) begin : cmd_driver
    rating_cmd_t w;
    if (rst_n && (!in_valid || word_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        w = pending_cmds.pop_front();
        in_valid     <= 1'b1;
        in_cmd       <= w.cmd;
        in_user_key  <= w.user;
        in_item_key  <= w.itm;
        in_rating_in <= w.rating;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long hold-offs let the block back up into its input
  always @(negedge clk) begin : reply_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_index < 2 &&
                 replies_seen >= (hold_index == 0 ? 150 : 2 * total_cmds / 3 + 20)) begin
      hold_index <= hold_index + 1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : reply_monitor
    rating_cmd_t   w;
    rating_reply_t want;
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        w.cmd    = cmd_t'(in_cmd);
        w.user   = in_user_key;
        w.itm    = in_item_key;
        w.rating = in_rating_in;
        due_replies.push_back(apply_to_table(w));
        words_taken <= words_taken + 1;
      end
      if (out_valid && !out_stall) begin
        replies_seen <= replies_seen + 1;
        if (out_status < 6) status_tally[out_status]++;
        if (out_status == ST_VALUE && out_match_count > widest_average)
          widest_average = out_match_count;
        if (due_replies.size() == 0) begin
          mismatches++;
          $display("%0t unexpected word: expected none, got status %0d value %0d count %0d",
                   $time, out_status, out_value_out, out_match_count);
        end else begin
          want = due_replies.pop_front();
          if (out_status !== want.status) begin
            mismatches++;
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, want.status, out_status);
          end
          if (out_value_out !== want.value) begin
            mismatches++;
            $display("%0t value mismatch: expected %0d, got %0d",
                     $time, want.value, out_value_out);
          end
          if (out_match_count !== want.count) begin
            mismatches++;
            $display("%0t count mismatch: expected %0d, got %0d",
                     $time, want.count, out_match_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timed out with %0d words outstanding", $time, due_replies.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : run
    logic [KeyW-1:0] base;
    logic [KeyW-1:0] itm;
    int n;
    int pick;
    int len;
    int sel;
    for (int s = 0; s < TableEntries; s++) slot_valid[s] = 1'b0;
    for (int k = 0; k < 6; k++) status_tally[k] = 0;
    for (int u = 0; u < 6; u++) user_pool[u] = new_key();
    for (int i = 0; i < 3; i++) item_pool[i] = new_key();

    // empty table, key and rating extremes, truncation of negative means
    queue_cmd(CMD_GET,     '0,       '0,       RATING_MAX);
    queue_cmd(CMD_REMOVE,  '0,       '0,       RATING_MIN);
    queue_cmd(CMD_AVERAGE, KEY_ONES, '0,       '0);
    queue_cmd(CMD_INSERT,  '0,       '0,       RATING_MIN);
    queue_cmd(CMD_INSERT,  KEY_ONES, KEY_ONES, RATING_MAX);
    queue_cmd(CMD_INSERT,  '0,       '0,       16'sd1);
    queue_cmd(CMD_GET,     '0,       '0,       '0);
    queue_cmd(CMD_INSERT,  32'd1,    '0,       -16'sd2);
    queue_cmd(CMD_AVERAGE, KEY_ONES, '0,       '0);
    queue_cmd(CMD_INSERT,  32'd2,    '0,       -16'sd3);
    queue_cmd(CMD_AVERAGE, '0,       '0,       '0);
    queue_cmd(CMD_AVERAGE, '0,       KEY_ONES, '0);
    queue_cmd(CMD_INSERT,  '0,       KEY_ONES, RATING_MIN);
    queue_cmd(CMD_AVERAGE, '0,       KEY_ONES, '0);
    queue_cmd(CMD_INSERT,  '0,       KEY_ONES, RATING_MAX);
    queue_cmd(CMD_AVERAGE, 32'd7,    KEY_ONES, '0);
    queue_cmd(CMD_REMOVE,  '0,       '0,       '0);
    queue_cmd(CMD_REMOVE,  '0,       '0,       '0);
    queue_cmd(CMD_GET,     '0,       '0,       '0);
    queue_cmd(CMD_INSERT,  32'd5,    '0,       16'sd7);
    queue_cmd(CMD_GET,     KEY_ONES, KEY_ONES, '0);
    queue_cmd(CMD_GET,     KEY_ONES, '0,       '0);

    while (pending_cmds.size() < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // insert 60 to 72 entries of one item, poke it near or past capacity, then empty it
        queue_pool_drain();
        base = $urandom;
        itm  = new_key();
        n    = $urandom_range(60, 72);
        for (int k = 0; k < n; k++)
          queue_cmd(CMD_INSERT, base + k, itm, random_rating());
        queue_cmd(CMD_AVERAGE, new_key(), itm, random_rating());
        queue_cmd(CMD_INSERT, base, itm, random_rating());
        queue_cmd(CMD_INSERT, base - 1, itm, random_rating());
        queue_cmd(CMD_GET, base + 3, itm, random_rating());
        queue_cmd(CMD_AVERAGE, new_key(), itm, random_rating());
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(3) == 0) queue_cmd(CMD_GET, base + k, itm, random_rating());
          queue_cmd(CMD_REMOVE, base + k, itm, random_rating());
        end
        queue_cmd(CMD_AVERAGE, new_key(), itm, random_rating());
      end else if (pick < 85) begin
        user_pool[$urandom_range(5)] = new_key();
        if ($urandom_range(3) == 0) item_pool[$urandom_range(2)] = new_key();
        len = $urandom_range(20, 40);
        for (int k = 0; k < len; k++) begin
          sel  = $urandom_range(99);
          base = user_pool[$urandom_range(5)];
          itm  = item_pool[$urandom_range(2)];
          // a stray pair now and then, mostly misses
          if ($urandom_range(9) == 0) begin
            base = new_key();
            itm  = new_key();
          end
          if (sel < 40)      queue_cmd(CMD_INSERT,  base,      itm, random_rating());
          else if (sel < 60) queue_cmd(CMD_REMOVE,  base,      itm, random_rating());
          else if (sel < 85) queue_cmd(CMD_GET,     base,      itm, random_rating());
          else               queue_cmd(CMD_AVERAGE, new_key(), itm, random_rating());
        end
      end else begin
        queue_pool_drain();
      end
    end
    total_cmds = pending_cmds.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid || due_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words checked: %0d added, %0d updated, %0d removed, %0d missed, %0d full",
             replies_seen, status_tally[ST_ADDED], status_tally[ST_UPDATED],
             status_tally[ST_REMOVED], status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
    $display("%0d value words, largest set averaged %0d entries, %0d mismatches",
             status_tally[ST_VALUE], widest_average, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
